### src/string_escape_decoder_macros.svh
// assertion helpers shared by the decoder modules
`ifndef STRING_ESCAPE_DECODER_MACROS_SVH
`define STRING_ESCAPE_DECODER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SED_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sed_pkg.sv
package sed_pkg;

    localparam logic [7:0] CH_BSL   = 8'h5C;  // backslash
    localparam logic [7:0] CH_X     = 8'h78;  // 'x'
    localparam logic [7:0] CH_DQ    = 8'h22;  // double quote
    localparam logic [7:0] CH_SQ    = 8'h27;  // single quote
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [5:0] DIGIT_NONE = 6'd63;
    localparam logic [5:0] BASE_OCT = 6'd8;
    localparam logic [5:0] BASE_HEX = 6'd16;

    // one decoded result
    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       run_last;
        logic       token_end;
    } res_t;

    // simple escape letters to control codes
    function automatic logic [7:0] simple_map(input logic [7:0] c);
        logic [7:0] r;
        begin
            case (c)
                8'h61:   r = 8'd7;   // a
                8'h62:   r = 8'd8;   // b
                8'h66:   r = 8'd12;  // f
                8'h6E:   r = 8'd10;  // n
                8'h72:   r = 8'd13;  // r
                8'h74:   r = 8'd9;   // t
                8'h76:   r = 8'd11;  // v
                default: r = c;
            endcase
            return r;
        end
    endfunction

    // digit value: decimal, then letters from 10 in either case
    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        begin
            if (c >= 8'h30 && c <= 8'h39)
                d = c - 8'h30;
            else if (c >= 8'h61 && c <= 8'h7A)
                d = c - 8'h61 + 8'd10;
            else if (c >= 8'h41 && c <= 8'h5A)
                d = c - 8'h41 + 8'd10;
            else
                d = {2'b00, DIGIT_NONE};
            return d[5:0];
        end
    endfunction

endpackage

### src/sed_decode.sv
`include "string_escape_decoder_macros.svh"

module sed_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        c,
    input  logic              last,
    output sed_pkg::res_t     r0,
    output sed_pkg::res_t     r1,
    output logic [1:0]        n
);
    import sed_pkg::*;

    typedef enum logic [1:0] {PH_START, PH_NORMAL, PH_ESCAPE, PH_NUMERIC} phase_t;

    phase_t     phase_reg, phase_next;
    logic       quoted_reg, quoted_next;
    logic       hex_reg, hex_next;
    logic [7:0] ev_reg, ev_next;

    logic [5:0] dig;
    logic       is_dec, is_x, is_bsl, num_ok;
    logic [7:0] ev_acc;
    logic [1:0] e_n;
    logic [7:0] e0, e1;

    assign dig    = digit_of(c);
    assign is_dec = (c >= 8'h30) && (c <= 8'h39);
    assign is_x   = (c == CH_X);
    assign is_bsl = (c == CH_BSL);
    assign num_ok = hex_reg ? (dig < BASE_HEX) : (dig < BASE_OCT);
    assign ev_acc = hex_reg ? {ev_reg[3:0], dig[3:0]} : {ev_reg[4:0], dig[2:0]};

    always_comb
    begin
        phase_next  = phase_reg;
        quoted_next = quoted_reg;
        hex_next    = hex_reg;
        ev_next     = ev_reg;
        e_n = 2'd0;
        e0  = CH_NUL;
        e1  = CH_NUL;
        case (phase_reg)
            PH_START:
            begin
                phase_next = PH_NORMAL;
                if (!last && (c == CH_DQ || c == CH_SQ))
                begin
                    quoted_next = 1'b1;
                end
                else
                begin
                    quoted_next = 1'b0;
                    if (is_bsl && !last)
                        phase_next = PH_ESCAPE;
                    else
                    begin
                        e_n = 2'd1;
                        e0  = is_bsl ? CH_NUL : c;
                    end
                end
            end
            PH_NORMAL:
            begin
                if (!(last && quoted_reg))
                begin
                    if (is_bsl && !last)
                        phase_next = PH_ESCAPE;
                    else
                    begin
                        e_n = 2'd1;
                        e0  = is_bsl ? CH_NUL : c;
                    end
                end
            end
            PH_ESCAPE:
            begin
                if (last && quoted_reg)
                begin
                    e_n = 2'd1;
                    e0  = (is_dec || is_x) ? CH_NUL : simple_map(c);
                end
                else if (is_dec)
                begin
                    if (dig < BASE_OCT)
                    begin
                        phase_next = PH_NUMERIC;
                        hex_next   = 1'b0;
                        ev_next    = {2'b00, dig};
                        if (last)
                        begin
                            e_n = 2'd1;
                            e0  = {2'b00, dig};
                        end
                    end
                    else
                    begin
                        // 8 or 9 ends an empty octal escape
                        phase_next = PH_NORMAL;
                        e_n = 2'd2;
                        e0  = CH_NUL;
                        e1  = c;
                    end
                end
                else if (is_x)
                begin
                    phase_next = PH_NUMERIC;
                    hex_next   = 1'b1;
                    ev_next    = CH_NUL;
                    if (last)
                    begin
                        e_n = 2'd1;
                        e0  = CH_NUL;
                    end
                end
                else
                begin
                    phase_next = PH_NORMAL;
                    e_n = 2'd1;
                    e0  = simple_map(c);
                end
            end
            PH_NUMERIC:
            begin
                if (last && quoted_reg)
                begin
                    e_n = 2'd1;
                    e0  = ev_reg;
                end
                else if (num_ok)
                begin
                    ev_next = ev_acc;
                    if (last)
                    begin
                        e_n = 2'd1;
                        e0  = ev_acc;
                    end
                end
                else
                begin
                    // flush value, then decode the stopping char normally
                    e0 = ev_reg;
                    phase_next = PH_NORMAL;
                    if (is_bsl && !last)
                    begin
                        e_n = 2'd1;
                        phase_next = PH_ESCAPE;
                    end
                    else
                    begin
                        e_n = 2'd2;
                        e1  = is_bsl ? CH_NUL : c;
                    end
                end
            end
            default:
            begin
                phase_next = PH_START;
            end
        endcase
        if (last)
        begin
            phase_next  = PH_START;
            quoted_next = 1'b0;
            hex_next    = 1'b0;
            ev_next     = CH_NUL;
        end
    end

    always_comb
    begin
        r0.ch        = (e_n == 2'd0) ? CH_NUL : e0;
        r0.valid     = (e_n != 2'd0);
        r0.run_last  = (e_n != 2'd2);
        r0.token_end = last && (e_n != 2'd2);
        r1.ch        = e1;
        r1.valid     = 1'b1;
        r1.run_last  = 1'b1;
        r1.token_end = last;
        n = (e_n == 2'd0 && last) ? 2'd1 : e_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            quoted_reg <= 1'b0;
            hex_reg    <= 1'b0;
            ev_reg     <= CH_NUL;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            quoted_reg <= quoted_next;
            hex_reg    <= hex_next;
            ev_reg     <= ev_next;
        end
    end

    `SED_ASSERT_NEXT(a_token_reset, fire && last, phase_reg == PH_START && !quoted_reg, "state not cleared at token end")
    `SED_ASSERT_NOW(a_end_has_result, last, n != 2'd0, "token end with no result")
    `SED_ASSERT_NOW(a_quote_in_body, quoted_reg, phase_reg != PH_START, "quoted mode at token start")

endmodule

### src/sed_out_buf.sv
`include "string_escape_decoder_macros.svh"

module sed_out_buf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [1:0]    n,
    input  sed_pkg::res_t r0,
    input  sed_pkg::res_t r1,
    input  logic          stall,
    output logic          valid,
    output sed_pkg::res_t head,
    output logic          free
);
    import sed_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    res_t       slot0_reg, slot0_next;
    res_t       slot1_reg, slot1_next;
    logic       take;

    assign valid = (cnt_reg != 2'd0);
    assign head  = slot0_reg;
    assign take  = valid && !stall;
    assign free  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && take);

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (push)
        begin
            cnt_next   = n;
            slot0_next = r0;
            slot1_next = r1;
        end
        else if (take)
        begin
            if (cnt_reg == 2'd2)
            begin
                cnt_next   = 2'd1;
                slot0_next = slot1_reg;
            end
            else
                cnt_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    `SED_ASSERT_NOW(a_push_free, push, free, "result pushed into occupied buffer")
    `SED_ASSERT_NOW(a_cnt_range, 1'b1, cnt_reg != 2'd3, "result count out of range")
    `SED_ASSERT_NEXT(a_pair_drain, cnt_reg == 2'd2 && take, cnt_reg == 2'd1, "second result lost")

endmodule

### src/string_escape_decoder.sv
// channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------------
// item     | item_valid / item_stall    | char_in[7:0], token_last
// result   | result_valid / result_stall| char_out[7:0], char_valid, run_last, token_end
//
// one item per cycle while not stalled; input register -> decode -> result register
// an item that decodes to two results holds the next result-producing request in the
// input register until the result buffer is down to one result and that one is taken
// reset (rst_n low, async) returns decode to token start and empties both stages
// result_stall backs up into item_stall within the same cycle through the
// input register; nothing is dropped
module string_escape_decoder (
    input  logic       clk,
    input  logic       rst_n,
    // item channel
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [7:0] char_in,
    input  logic       token_last,
    // result channel
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] char_out,
    output logic       char_valid,
    output logic       run_last,
    output logic       token_end
);
    import sed_pkg::*;

    // input register stage
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_char_reg;
    logic       s1_last_reg;

    logic       item_take;
    logic       fire;      // decode consumes the held request
    logic       buf_free;
    logic [1:0] dec_n;
    res_t       dec_r0, dec_r1;
    res_t       head;

    // a request producing nothing never waits on the result side
    assign fire       = s1_valid_reg && (dec_n == 2'd0 || buf_free);
    assign item_stall = s1_valid_reg && !fire;
    assign item_take  = item_valid && !item_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_take)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s1_char_reg <= char_in;
            s1_last_reg <= token_last;
        end
    end

    // escape decode and token state
    sed_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .c     (s1_char_reg),
        .last  (s1_last_reg),
        .r0    (dec_r0),
        .r1    (dec_r1),
        .n     (dec_n)
    );

    // result register, holds up to two results of one request
    sed_out_buf u_out_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fire && dec_n != 2'd0),
        .n     (dec_n),
        .r0    (dec_r0),
        .r1    (dec_r1),
        .stall (result_stall),
        .valid (result_valid),
        .head  (head),
        .free  (buf_free)
    );

    assign char_out   = head.ch;
    assign char_valid = head.valid;
    assign run_last   = head.run_last;
    assign token_end  = head.token_end;

endmodule
